// ===== rtl/double_ended_queue_macros.svh =====
// Assertion macros for the double-ended queue checker.
// No dependencies; include by bare file name where assertions are written.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// No dependencies; imported by deq_ctrl, the top level and the checker.
package deq_pkg;

   localparam int DATA_BITS  = 32;
   localparam int COUNT_BITS = 5;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_REAR  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]           command;
      logic [DATA_BITS-1:0] element_data;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]  result_data;
      logic [1:0]            result_status;
      logic [COUNT_BITS-1:0] element_count;
      logic                  now_empty;
   } rsp_type;

   typedef struct packed {
      logic write_en;
      logic read_en;
   } mem_ctl_type;

   typedef struct packed {
      logic                  valid;
      logic                  read_back;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
      logic                  empty;
   } rsp_meta_type;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deq_ctrl.sv =====
// Ring control for the double-ended queue: head index, count, entry address
// and the registered response status. Depends on deq_pkg.
module deq_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                command,
   output deq_pkg::mem_ctl_type      mem_ctl,
   output logic [$clog2(DEPTH)-1:0]  mem_addr,
   output deq_pkg::rsp_meta_type     meta
);
   import deq_pkg::*;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);
   localparam logic [SUM_BITS-1:0] DEPTH_SUM = SUM_BITS'(DEPTH);

   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   rsp_meta_type        meta_ff, meta_in;

   logic                is_full;
   logic                is_empty;
   logic [IDX_BITS-1:0] head_dec;
   logic [IDX_BITS-1:0] head_inc;
   logic [CNT_BITS-1:0] rear_off;
   logic [SUM_BITS-1:0] rear_sum;
   logic [IDX_BITS-1:0] rear_pos;
   status_type          status;
   logic                read_back;

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - IDX_BITS'(1);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_BITS'(1);

   // Push rear lands one past the rear word; the rear word sits at count - 1.
   assign rear_off = (command == CMD_PUSH_REAR) ? count_ff : count_ff - CNT_BITS'(1);
   assign rear_sum = SUM_BITS'(head_ff) + SUM_BITS'(rear_off);
   assign rear_pos = (rear_sum >= DEPTH_SUM) ? IDX_BITS'(rear_sum - DEPTH_SUM)
                                             : IDX_BITS'(rear_sum);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      mem_ctl   = '0;
      mem_addr  = head_ff;
      status    = STATUS_OK;
      read_back = 1'b0;
      if (accept) begin
         case (command)
            CMD_PUSH_FRONT: begin
               if (is_full) begin
                  status = STATUS_FULL;
               end else begin
                  head_in          = head_dec;
                  mem_addr         = head_dec;
                  mem_ctl.write_en = 1'b1;
                  count_in         = count_ff + CNT_BITS'(1);
               end
            end
            CMD_PUSH_REAR: begin
               if (is_full) begin
                  status = STATUS_FULL;
               end else begin
                  mem_addr         = rear_pos;
                  mem_ctl.write_en = 1'b1;
                  count_in         = count_ff + CNT_BITS'(1);
               end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
               if (is_empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  mem_addr        = head_ff;
                  mem_ctl.read_en = 1'b1;
                  read_back       = 1'b1;
                  if (command == CMD_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            CMD_POP_REAR, CMD_PEEK_REAR: begin
               if (is_empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  mem_addr        = rear_pos;
                  mem_ctl.read_en = 1'b1;
                  read_back       = 1'b1;
                  if (command == CMD_POP_REAR) begin
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            default: begin
               // unused codes leave the store untouched
            end
         endcase
      end

      meta_in.valid     = accept;
      meta_in.read_back = read_back;
      meta_in.status    = status;
      meta_in.count     = COUNT_BITS'(count_in);
      meta_in.empty     = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         meta_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         meta_ff  <= meta_in;
      end
   end

   assign meta = meta_ff;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: ring control plus word store RAM.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
//   Port group   Direction  Handshake              Payload
//   req_         in         start high, busy low   req_payload (command, element_data)
//   rsp_         out        rsp_strobe, one cycle  rsp_payload (data, status, count, empty)
//
// One command per cycle; its response shows in the cycle after the transfer.
// The word store read data is registered, which sets the response delay.
// busy stays low: a read and a write never target the same entry in one cycle.
// Synchronous reset empties the queue at once; no clearing pass is needed.
// The receiver cannot stall, so each response is shown exactly once.
module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  deq_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output deq_pkg::rsp_type rsp_payload
);
   import deq_pkg::*;

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int STORE_BITS = (DATA_WIDTH < DATA_BITS) ? DATA_WIDTH : DATA_BITS;

   logic                  accept;
   mem_ctl_type           mem_ctl;
   logic [IDX_BITS-1:0]   mem_addr;
   rsp_meta_type          meta;
   logic [STORE_BITS-1:0] rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   deq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (req_payload.command),
      .mem_ctl  (mem_ctl),
      .mem_addr (mem_addr),
      .meta     (meta)
   );

   deq_ram #(
      .WIDTH(STORE_BITS),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_ctl.write_en),
      .wr_addr (mem_addr),
      .wr_data (req_payload.element_data[STORE_BITS-1:0]),
      .rd_en   (mem_ctl.read_en),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe                = meta.valid;
   assign rsp_payload.result_data   = meta.read_back ? DATA_BITS'(rd_data) : '0;
   assign rsp_payload.result_status = meta.status;
   assign rsp_payload.element_count = meta.count;
   assign rsp_payload.now_empty     = meta.empty;

endmodule

// ===== rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input deq_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input deq_pkg::rsp_type rsp_payload
);
   import deq_pkg::*;

   logic accept;
   logic rsp_err;
   logic rsp_empty;
   logic rsp_no_data;

   assign accept      = start && !busy;
   assign rsp_err     = rsp_strobe && (rsp_payload.result_status != STATUS_OK);
   assign rsp_empty   = rsp_strobe && (rsp_payload.result_status == STATUS_EMPTY);
   assign rsp_no_data = (rsp_payload.result_data == '0);

   `DEQ_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_strobe, "transfer without response")

   `DEQ_ASSERT_NOW(a_rsp_has_req, rsp_strobe, $past(accept), "response without transfer")

   `DEQ_ASSERT_NOW(a_err_zero_data, rsp_err, rsp_no_data, "error response carries data")

   `DEQ_ASSERT_NOW(a_empty_status, rsp_empty, rsp_payload.now_empty, "empty status, nonempty store")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ===== bench/tb_double_ended_queue.sv =====
// Self-checking testbench for double_ended_queue: directed table, then biased random traffic.
// Depends on deq_pkg and the double_ended_queue RTL; a local ring model predicts each response.
`timescale 1ns / 100ps

module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1060;
   localparam int IDLE_LIMIT   = 200;
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;
   localparam logic [DATA_BITS-1:0] ALL_ONES = '1;

   typedef struct {
      logic [2:0]           cmd;
      logic [DATA_BITS-1:0] data;
      int                   reps;
      bit                   typed;
      rsp_type              want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // expectation typed into the directed table, carried alongside the transfer
   bit      drv_typed = 1'b0;
   rsp_type drv_want = '0;

   // predictor state
   logic [DATA_BITS-1:0]  ring_words [RING_DEPTH];
   logic [3:0]            ring_head;
   logic [COUNT_BITS-1:0] ring_count;

   rsp_type      pending_results [$];
   stim_row_type directed_rows [$];

   int error_count = 0;
   int idle_cycles = 0;
   int cmds_sent = 0;
   int full_refusals = 0;
   int empty_refusals = 0;
   int rsvd_cmds = 0;
   int results_seen = 0;

   double_ended_queue uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic rsp_type mk_rsp(logic [DATA_BITS-1:0] data, status_type status,
                                      int count, bit empty);
      rsp_type r;
      r.result_data   = data;
      r.result_status = status;
      r.element_count = COUNT_BITS'(count);
      r.now_empty     = empty;
      return r;
   endfunction

   task automatic add_row(logic [2:0] cmd, logic [DATA_BITS-1:0] data, int reps,
                          bit typed, rsp_type want);
      stim_row_type row;
      row.cmd   = cmd;
      row.data  = data;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Advance the ring model by one command and return the response it gives.
   function automatic rsp_type predict_deque_result(req_type req);
      rsp_type    r;
      logic [3:0] pos;
      r = '0;
      r.result_status = STATUS_OK;
      case (req.command)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (ring_count == COUNT_BITS'(RING_DEPTH)) begin
               r.result_status = STATUS_FULL;
            end else if (req.command == CMD_PUSH_FRONT) begin
               ring_head = ring_head - 4'd1;
               ring_words[ring_head] = req.element_data;
               ring_count++;
            end else begin
               pos = ring_head + ring_count[3:0];
               ring_words[pos] = req.element_data;
               ring_count++;
            end
         end
         CMD_POP_FRONT, CMD_PEEK_FRONT: begin
            if (ring_count == 0) begin
               r.result_status = STATUS_EMPTY;
            end else begin
               r.result_data = ring_words[ring_head];
               if (req.command == CMD_POP_FRONT) begin
                  ring_head = ring_head + 4'd1;
                  ring_count--;
               end
            end
         end
         CMD_POP_REAR, CMD_PEEK_REAR: begin
            if (ring_count == 0) begin
               r.result_status = STATUS_EMPTY;
            end else begin
               pos = ring_head + ring_count[3:0] - 4'd1;
               r.result_data = ring_words[pos];
               if (req.command == CMD_POP_REAR) ring_count--;
            end
         end
         default: ;
      endcase
      r.element_count = ring_count;
      r.now_empty     = (ring_count == 0);
      return r;
   endfunction

   // Predict on each input transfer, check each response, and watch for a hang.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type pred;
      bit      moved;
      moved = 1'b0;
      if (reset) begin
         ring_head  = '0;
         ring_count = '0;
      end else begin
         if (start && !busy) begin
            moved = 1'b1;
            pred = predict_deque_result(req_payload);
            if (pred.result_status == STATUS_FULL) full_refusals++;
            if (pred.result_status == STATUS_EMPTY) empty_refusals++;
            if (req_payload.command > CMD_PEEK_REAR) rsvd_cmds++;
            pending_results.push_back(drv_typed ? drv_want : pred);
         end
         if (rsp_strobe) begin
            moved = 1'b1;
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("unexpected response: data %h status %0d count %0d",
                      rsp_payload.result_data, rsp_payload.result_status,
                      rsp_payload.element_count);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.result_data !== want.result_data) begin
                  $error("result_data: expected %h, actual %h",
                         want.result_data, rsp_payload.result_data);
                  error_count++;
               end
               if (rsp_payload.result_status !== want.result_status) begin
                  $error("result_status: expected %0d, actual %0d",
                         want.result_status, rsp_payload.result_status);
                  error_count++;
               end
               if (rsp_payload.element_count !== want.element_count) begin
                  $error("element_count: expected %0d, actual %0d",
                         want.element_count, rsp_payload.element_count);
                  error_count++;
               end
               if (rsp_payload.now_empty !== want.now_empty) begin
                  $error("now_empty: expected %0d, actual %0d",
                         want.now_empty, rsp_payload.now_empty);
                  error_count++;
               end
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one command and hold it until the transfer; returns at the next falling edge.
   task automatic send_command(logic [2:0] cmd, logic [DATA_BITS-1:0] data,
                               bit typed, rsp_type want);
      start                    <= 1'b1;
      req_payload.command      <= cmd;
      req_payload.element_data <= data;
      drv_typed                <= typed;
      drv_want                 <= want;
      do @(posedge clock); while (busy);
      cmds_sent++;
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int                   fill_mode;
      bit                   gaps_on;
      int                   pick;
      int                   real_items;
      logic [2:0]           cmd;
      logic [DATA_BITS-1:0] data;

      // empty store: every read is refused, reserved codes change nothing
      add_row(CMD_POP_FRONT,  '0, 1, 1, mk_rsp('0, STATUS_EMPTY, 0, 1));
      add_row(CMD_POP_REAR,   '0, 1, 1, mk_rsp('0, STATUS_EMPTY, 0, 1));
      add_row(CMD_PEEK_FRONT, ALL_ONES, 1, 1, mk_rsp('0, STATUS_EMPTY, 0, 1));
      add_row(CMD_PEEK_REAR,  ALL_ONES, 1, 1, mk_rsp('0, STATUS_EMPTY, 0, 1));
      add_row(CMD_RSVD_6, ALL_ONES, 1, 1, mk_rsp('0, STATUS_OK, 0, 1));
      add_row(CMD_RSVD_7, ALL_ONES, 1, 1, mk_rsp('0, STATUS_OK, 0, 1));
      // push at both ends, head wraps below zero on the first front push
      add_row(CMD_PUSH_FRONT, ALL_ONES, 1, 1, mk_rsp('0, STATUS_OK, 1, 0));
      add_row(CMD_PUSH_REAR,  '0, 1, 1, mk_rsp('0, STATUS_OK, 2, 0));
      add_row(CMD_PEEK_FRONT, '0, 1, 1, mk_rsp(ALL_ONES, STATUS_OK, 2, 0));
      add_row(CMD_PEEK_REAR,  ALL_ONES, 1, 1, mk_rsp('0, STATUS_OK, 2, 0));
      add_row(CMD_PUSH_REAR,  32'h8000_0001, 7, 0, '0);
      add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFE, 7, 0, '0);
      // full store: pushes refused, then pops drain it to empty and a pop is refused
      add_row(CMD_PUSH_FRONT, 32'h1234_5678, 1, 1, mk_rsp('0, STATUS_FULL, 16, 0));
      add_row(CMD_PUSH_REAR,  32'h8765_4321, 1, 1, mk_rsp('0, STATUS_FULL, 16, 0));
      add_row(CMD_RSVD_6, '0, 1, 1, mk_rsp('0, STATUS_OK, 16, 0));
      add_row(CMD_PEEK_FRONT, '0, 1, 0, '0);
      add_row(CMD_PEEK_REAR,  '0, 1, 0, '0);
      add_row(CMD_POP_REAR,   '0, 1, 0, '0);
      add_row(CMD_POP_FRONT,  '0, 15, 0, '0);
      add_row(CMD_POP_FRONT,  '0, 1, 1, mk_rsp('0, STATUS_EMPTY, 0, 1));
      add_row(CMD_PUSH_REAR,  32'hDEAD_BEEF, 1, 0, '0);
      add_row(CMD_POP_FRONT,  '0, 1, 0, '0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++) begin
            send_command(directed_rows[i].cmd, directed_rows[i].data + DATA_BITS'(k),
                         directed_rows[i].typed, directed_rows[i].want);
            idle_for($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
         end
      end
      drain_responses();

      // random traffic: fill, drain and balanced stretches so both ends see full and empty
      real_items = 0;
      fill_mode  = 0;
      gaps_on    = 1'b0;
      for (int n = 0; real_items < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            fill_mode = $urandom_range(0, 2);
            gaps_on   = ($urandom_range(0, 2) != 0);
         end
         if (n > 0 && n % 300 == 0) drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
         end else if (pick < (fill_mode == 0 ? 64 : fill_mode == 1 ? 24 : 44)) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
         end else if (pick < (fill_mode == 1 ? 84 : fill_mode == 0 ? 84 : 74)) begin
            cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_PEEK_FRONT : CMD_PEEK_REAR;
         end
         case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = ALL_ONES;
            default: data = $urandom;
         endcase
         if (cmd <= CMD_PEEK_REAR) real_items++;
         send_command(cmd, data, 1'b0, '0);
         idle_for(gaps_on ? $urandom_range(0, 4) : 0);
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Sent %0d commands (%0d reserved codes), checked %0d responses.",
               cmds_sent, rsvd_cmds, results_seen);
      $display("Refused pushes on a full store: %0d, reads on an empty store: %0d.",
               full_refusals, empty_refusals);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
